// ----- rtl/core/projectile_motion_step_assert.svh -----
// Assertion macros shared by the projectile motion step RTL.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef PROJECTILE_MOTION_STEP_ASSERT_SVH
`define PROJECTILE_MOTION_STEP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PMS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pms_pkg.sv -----
// Package for the projectile motion step: widths, constants, types and helpers.
// Used by the channel interfaces, the lanes, the merge stage and the top level.
package pms_pkg;

    localparam int WORD_W   = 32;
    localparam int DT_W     = 17;
    localparam int K_W      = 16;
    localparam int HALF_W   = 18;
    localparam int FLAGS_W  = 4;
    localparam int FRAC_W   = 16;
    localparam int GPROD_W  = 49;
    localparam int PROD_W   = 51;
    localparam int RSUM_W   = 52;
    localparam int DELTA_W  = 36;
    localparam int WIDE_W   = 37;
    localparam int SQ_W     = 26;
    localparam int SQSUM_W  = 28;
    localparam int NUM_LANES = 3;
    localparam int CFG_IDX_W = 3;

    localparam int FLAG_REST    = 0;
    localparam int FLAG_NO_GRAV = 1;
    localparam int FLAG_HALF    = 2;
    localparam int FLAG_LIQUID  = 3;

    localparam logic [K_W-1:0]     SCALE_HALF  = 16'd32768;
    localparam logic [K_W-1:0]     SCALE_FIFTH = 16'd13107;
    localparam logic [WORD_W-1:0]  MAG_LIMIT   = 32'd6554;
    localparam logic [SQSUM_W-1:0] SMALL_MAGSQ = 28'd42949673;

    typedef logic signed [WORD_W-1:0]  t_word;
    typedef logic signed [GPROD_W-1:0] t_gprod;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [RSUM_W-1:0]  t_rsum;
    typedef logic signed [DELTA_W-1:0] t_delta;
    typedef logic signed [WIDE_W-1:0]  t_wide;

    localparam t_word  WORD_MAX = t_word'(32'h7fff_ffff);
    localparam t_word  WORD_MIN = t_word'(32'h8000_0000);
    localparam t_rsum  RSUM_RND = t_rsum'(32768);
    localparam t_gprod GPROD_RND = t_gprod'(32768);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NGRAV_X = 3'd0,
        CFG_NGRAV_Y = 3'd1,
        CFG_NGRAV_Z = 3'd2,
        CFG_LGRAV_X = 3'd3,
        CFG_LGRAV_Y = 3'd4,
        CFG_LGRAV_Z = 3'd5,
        CFG_NDT     = 3'd6,
        CFG_LDT     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

    typedef struct packed {
        logic            acc_big;
        logic [SQ_W-1:0] acc_sq;
        logic            vel_big;
        logic [SQ_W-1:0] vel_sq;
    } t_lane_mag;

    typedef struct packed {
        logic acc_small;
        logic vel_small;
    } t_small;

    // Divides by 2^16, rounding to nearest with ties toward plus infinity.
    function automatic t_delta rnd16(input t_rsum x);
        t_rsum b;
        b = x + RSUM_RND;
        return t_delta'(b >>> FRAC_W);
    endfunction

    function automatic t_word sat_word(input t_wide v);
        logic [WIDE_W-WORD_W:0] top;
        top = v[WIDE_W-1:WORD_W-1];
        if ((&top) || !(|top)) begin
            return t_word'(v);
        end else begin
            return v[WIDE_W-1] ? WORD_MIN : WORD_MAX;
        end
    endfunction

endpackage

// ----- rtl/core/pms_item_if.sv -----
// Input channel of the projectile motion step: one object per item.
// Depends on pms_pkg for the field types.
interface pms_item_if import pms_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_word                pos_x;
    t_word                pos_y;
    t_word                pos_z;
    t_word                vel_x;
    t_word                vel_y;
    t_word                vel_z;
    t_word                accel_x;
    t_word                accel_y;
    t_word                accel_z;
    logic [FLAGS_W-1:0]   motion_flags;

    modport source (
        output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               accel_x, accel_y, accel_z, motion_flags,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               accel_x, accel_y, accel_z, motion_flags,
        output ready
    );
endinterface

// ----- rtl/core/pms_result_if.sv -----
// Output channel of the projectile motion step: one updated object per item.
// Depends on pms_pkg for the field types.
interface pms_result_if import pms_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word new_pos_x;
    t_word new_pos_y;
    t_word new_pos_z;
    t_word new_vel_x;
    t_word new_vel_y;
    t_word new_vel_z;
    logic  moved;

    modport source (
        output valid, new_pos_x, new_pos_y, new_pos_z,
               new_vel_x, new_vel_y, new_vel_z, moved,
        input  ready
    );
    modport sink (
        input  valid, new_pos_x, new_pos_y, new_pos_z,
               new_vel_x, new_vel_y, new_vel_z, moved,
        output ready
    );
endinterface

// ----- rtl/core/pms_lane.sv -----
// One axis of the motion step: products, rounding and saturation in four stages.
// Depends on pms_pkg; the magnitude test result comes from pms_merge.
module pms_lane import pms_pkg::*; (
    input  logic              i_clk,
    input  t_stage_en         i_en,
    input  t_word             i_pos,
    input  t_word             i_vel,
    input  t_word             i_acc,
    input  t_word             i_grav,
    input  logic [DT_W-1:0]   i_dt1,
    input  logic [K_W-1:0]    i_k1,
    input  logic [DT_W-1:0]   i_dt2,
    input  logic [HALF_W-1:0] i_half2,
    input  logic              i_rest3,
    input  t_small            i_small3,
    output t_lane_mag         o_mag2,
    output t_word             o_new_pos,
    output t_word             o_new_vel
);

    t_word     r_pos1, r_vel1, r_acc1, r_grav1;
    t_word     r_pos2, r_vel2, r_acc2;
    t_gprod    r_gprod2;
    t_prod     r_accdt2, r_veldt2;
    t_lane_mag r_mag2;
    t_word     r_pos3, r_vel3;
    t_prod     r_accdt3, r_veldt3, r_gsdt3, r_acchalf3;
    t_word     r_pos4, r_vel4;

    t_gprod    n_gprod2;
    t_prod     n_accdt2, n_veldt2;
    t_lane_mag n_mag2;
    t_word     n_gs;
    t_prod     n_gsdt3, n_acchalf3;
    t_word     n_pos4, n_vel4;

    logic [WORD_W-1:0] acc_abs, vel_abs;
    t_rsum  dv_sum, dp_sum;
    t_word  vel_eff;

    always_comb begin
        acc_abs  = r_acc1[WORD_W-1] ? (~r_acc1 + 32'd1) : r_acc1;
        vel_abs  = r_vel1[WORD_W-1] ? (~r_vel1 + 32'd1) : r_vel1;
        n_mag2.acc_big = (acc_abs >= MAG_LIMIT);
        n_mag2.vel_big = (vel_abs >= MAG_LIMIT);
        n_mag2.acc_sq  = SQ_W'(acc_abs[12:0]) * SQ_W'(acc_abs[12:0]);
        n_mag2.vel_sq  = SQ_W'(vel_abs[12:0]) * SQ_W'(vel_abs[12:0]);
        n_gprod2 = GPROD_W'(r_grav1) * GPROD_W'($signed({1'b0, i_k1}));
        n_accdt2 = PROD_W'(r_acc1) * PROD_W'($signed({1'b0, i_dt1}));
        n_veldt2 = PROD_W'(r_vel1) * PROD_W'($signed({1'b0, i_dt1}));
    end

    always_comb begin
        n_gs       = t_word'((r_gprod2 + GPROD_RND) >>> FRAC_W);
        n_gsdt3    = PROD_W'(n_gs) * PROD_W'($signed({1'b0, i_dt2}));
        n_acchalf3 = PROD_W'(r_acc2) * PROD_W'($signed({1'b0, i_half2}));
    end

    always_comb begin
        dv_sum  = RSUM_W'(r_gsdt3) + (i_small3.acc_small ? '0 : RSUM_W'(r_accdt3));
        dp_sum  = (i_small3.acc_small ? '0 : RSUM_W'(r_acchalf3))
                + (i_small3.vel_small ? '0 : RSUM_W'(r_veldt3));
        vel_eff = i_small3.vel_small ? '0 : r_vel3;
        if (i_rest3) begin
            n_pos4 = r_pos3;
            n_vel4 = r_vel3;
        end else begin
            n_pos4 = sat_word(WIDE_W'(r_pos3) + WIDE_W'(rnd16(dp_sum)));
            n_vel4 = sat_word(WIDE_W'(vel_eff) + WIDE_W'(rnd16(dv_sum)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_pos1  <= i_pos;
            r_vel1  <= i_vel;
            r_acc1  <= i_acc;
            r_grav1 <= i_grav;
        end
        if (i_en.s2) begin
            r_pos2   <= r_pos1;
            r_vel2   <= r_vel1;
            r_acc2   <= r_acc1;
            r_gprod2 <= n_gprod2;
            r_accdt2 <= n_accdt2;
            r_veldt2 <= n_veldt2;
            r_mag2   <= n_mag2;
        end
        if (i_en.s3) begin
            r_pos3     <= r_pos2;
            r_vel3     <= r_vel2;
            r_accdt3   <= r_accdt2;
            r_veldt3   <= r_veldt2;
            r_gsdt3    <= n_gsdt3;
            r_acchalf3 <= n_acchalf3;
        end
        if (i_en.s4) begin
            r_pos4 <= n_pos4;
            r_vel4 <= n_vel4;
        end
    end

    assign o_mag2    = r_mag2;
    assign o_new_pos = r_pos4;
    assign o_new_vel = r_vel4;

endmodule

// ----- rtl/core/pms_merge.sv -----
// Merge stage: adds the squared components of all lanes and flags small vectors.
// Depends on pms_pkg; fed by the stage-two magnitude terms of each pms_lane.
module pms_merge import pms_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_lane_mag i_mag [NUM_LANES],
    output t_small    o_small
);

    t_small              r_small;
    t_small              n_small;
    logic [SQSUM_W-1:0]  acc_sum, vel_sum;
    logic                acc_big, vel_big;

    always_comb begin
        acc_sum = '0;
        vel_sum = '0;
        acc_big = 1'b0;
        vel_big = 1'b0;
        for (int l = 0; l < NUM_LANES; l++) begin
            acc_sum = acc_sum + SQSUM_W'(i_mag[l].acc_sq);
            vel_sum = vel_sum + SQSUM_W'(i_mag[l].vel_sq);
            acc_big = acc_big | i_mag[l].acc_big;
            vel_big = vel_big | i_mag[l].vel_big;
        end
        n_small.acc_small = !acc_big && (acc_sum < SMALL_MAGSQ);
        n_small.vel_small = !vel_big && (vel_sum < SMALL_MAGSQ);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_small <= n_small;
        end
    end

    assign o_small = r_small;

endmodule

// ----- rtl/core/projectile_motion_step.sv -----
// Top level of the projectile motion step: configuration registers, pipeline
// control, three axis lanes and the magnitude merge. Depends on pms_pkg,
// pms_item_if, pms_result_if, pms_lane, pms_merge and the assertion header.
//
//   Channel   Direction  Handshake        Contents
//   i_item    in         valid / ready    position, velocity, acceleration, flags
//   o_result  out        valid / ready    new position, new velocity, moved
//   i_cfg_*   in         write enable     gravity vectors and time steps
//
// One item enters per cycle unless a stalled output has filled the stages; its
// result leaves from the fourth stage. The four pipeline stages each hold one
// item and carry the multiply, round and saturate steps of the lanes.
// A stalled output holds its item and the stages behind it fill up; the input
// stays ready while any stage ahead of it can still move.
// Reset clears the configuration registers and all stage valid bits.
`include "projectile_motion_step_assert.svh"

module projectile_motion_step import pms_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pms_item_if.sink             i_item,
    pms_result_if.source         o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    t_word             r_ngrav [NUM_LANES];
    t_word             r_lgrav [NUM_LANES];
    logic [DT_W-1:0]   r_ndt, r_ldt;

    logic              r_v1, r_v2, r_v3, r_v4;
    logic [DT_W-1:0]   r_dt1, r_dt2;
    logic [K_W-1:0]    r_k1;
    logic [HALF_W-1:0] r_half2;
    logic              r_rest1, r_rest2, r_rest3, r_moved4;

    logic              free1, free2, free3, free4;
    t_stage_en         en;
    logic              liquid;
    logic [DT_W-1:0]   n_dt1;
    logic [K_W-1:0]    n_k1;
    logic [2*DT_W:0]   dt_sq;
    logic [HALF_W-1:0] n_half2;

    t_word             lane_pos  [NUM_LANES];
    t_word             lane_vel  [NUM_LANES];
    t_word             lane_acc  [NUM_LANES];
    t_word             lane_grav [NUM_LANES];
    t_word             lane_npos [NUM_LANES];
    t_word             lane_nvel [NUM_LANES];
    t_lane_mag         lane_mag  [NUM_LANES];
    t_small            small3;

    always_comb begin
        free4 = !r_v4 || o_result.ready;
        free3 = !r_v3 || free4;
        free2 = !r_v2 || free3;
        free1 = !r_v1 || free2;
        en.s1 = i_item.valid && free1;
        en.s2 = r_v1 && free2;
        en.s3 = r_v2 && free3;
        en.s4 = r_v3 && free4;
    end

    assign i_item.ready = free1;

    always_comb begin
        liquid = i_item.motion_flags[FLAG_LIQUID];
        n_dt1  = liquid ? r_ldt : r_ndt;
        if (i_item.motion_flags[FLAG_NO_GRAV]) begin
            n_k1 = '0;
        end else if (i_item.motion_flags[FLAG_HALF]) begin
            n_k1 = SCALE_FIFTH;
        end else begin
            n_k1 = SCALE_HALF;
        end
        for (int l = 0; l < NUM_LANES; l++) begin
            lane_grav[l] = liquid ? r_lgrav[l] : r_ngrav[l];
        end
        lane_pos[0] = i_item.pos_x;
        lane_pos[1] = i_item.pos_y;
        lane_pos[2] = i_item.pos_z;
        lane_vel[0] = i_item.vel_x;
        lane_vel[1] = i_item.vel_y;
        lane_vel[2] = i_item.vel_z;
        lane_acc[0] = i_item.accel_x;
        lane_acc[1] = i_item.accel_y;
        lane_acc[2] = i_item.accel_z;
        dt_sq   = (2*DT_W+1)'(r_dt1) * (2*DT_W+1)'(r_dt1) + (2*DT_W+1)'(65536);
        n_half2 = dt_sq[2*DT_W:DT_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                r_ngrav[l] <= '0;
                r_lgrav[l] <= '0;
            end
            r_ndt <= '0;
            r_ldt <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_NGRAV_X: r_ngrav[0] <= t_word'(i_cfg_data);
                    CFG_NGRAV_Y: r_ngrav[1] <= t_word'(i_cfg_data);
                    CFG_NGRAV_Z: r_ngrav[2] <= t_word'(i_cfg_data);
                    CFG_LGRAV_X: r_lgrav[0] <= t_word'(i_cfg_data);
                    CFG_LGRAV_Y: r_lgrav[1] <= t_word'(i_cfg_data);
                    CFG_LGRAV_Z: r_lgrav[2] <= t_word'(i_cfg_data);
                    CFG_NDT:     r_ndt <= i_cfg_data[DT_W-1:0];
                    CFG_LDT:     r_ldt <= i_cfg_data[DT_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_v1 <= en.s1 || (r_v1 && !en.s2);
            r_v2 <= en.s2 || (r_v2 && !en.s3);
            r_v3 <= en.s3 || (r_v3 && !en.s4);
            r_v4 <= en.s4 || (r_v4 && !o_result.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en.s1) begin
            r_dt1   <= n_dt1;
            r_k1    <= n_k1;
            r_rest1 <= i_item.motion_flags[FLAG_REST];
        end
        if (en.s2) begin
            r_dt2   <= r_dt1;
            r_half2 <= n_half2;
            r_rest2 <= r_rest1;
        end
        if (en.s3) begin
            r_rest3 <= r_rest2;
        end
        if (en.s4) begin
            r_moved4 <= !r_rest3;
        end
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        pms_lane u_lane (
            .i_clk     (i_clk),
            .i_en      (en),
            .i_pos     (lane_pos[l]),
            .i_vel     (lane_vel[l]),
            .i_acc     (lane_acc[l]),
            .i_grav    (lane_grav[l]),
            .i_dt1     (r_dt1),
            .i_k1      (r_k1),
            .i_dt2     (r_dt2),
            .i_half2   (r_half2),
            .i_rest3   (r_rest3),
            .i_small3  (small3),
            .o_mag2    (lane_mag[l]),
            .o_new_pos (lane_npos[l]),
            .o_new_vel (lane_nvel[l])
        );
    end

    pms_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (en.s3),
        .i_mag   (lane_mag),
        .o_small (small3)
    );

    assign o_result.valid     = r_v4;
    assign o_result.new_pos_x = lane_npos[0];
    assign o_result.new_pos_y = lane_npos[1];
    assign o_result.new_pos_z = lane_npos[2];
    assign o_result.new_vel_x = lane_nvel[0];
    assign o_result.new_vel_y = lane_nvel[1];
    assign o_result.new_vel_z = lane_nvel[2];
    assign o_result.moved     = r_moved4;

    // A blocked third stage keeps its item for the next cycle.
    `PMS_ASSERT_NEXT(a_stage3_holds, i_clk, i_rst_n, r_v3 && !free4, r_v3,
        "stage three lost an item while the output was blocked")
    // A full first stage that cannot move must block the input.
    `PMS_ASSERT_IMPLY(a_input_blocked, i_clk, i_rst_n, r_v1 && !free2, !i_item.ready,
        "input accepted an item into a blocked first stage")

endmodule

// ----- tb/tb_projectile_motion_step.sv -----
// Self-checking testbench for projectile_motion_step: drives objects on the item
// channel, predicts each Euler step in Q16.16 and checks every result in order.
// Depends on pms_pkg, pms_item_if, pms_result_if and the projectile_motion_step RTL.
`timescale 1ns / 1ps

module tb_projectile_motion_step import pms_pkg::*; ();

    localparam int PIPE_LATENCY = 4;
    localparam logic [FLAGS_W-1:0] M_REST    = FLAGS_W'(1 << FLAG_REST);
    localparam logic [FLAGS_W-1:0] M_NO_GRAV = FLAGS_W'(1 << FLAG_NO_GRAV);
    localparam logic [FLAGS_W-1:0] M_HALF    = FLAGS_W'(1 << FLAG_HALF);
    localparam logic [FLAGS_W-1:0] M_LIQUID  = FLAGS_W'(1 << FLAG_LIQUID);

    typedef struct packed {
        t_word [2:0]        pos;
        t_word [2:0]        vel;
        t_word [2:0]        acc;
        logic [FLAGS_W-1:0] flags;
    } t_object;

    typedef struct packed {
        t_word [2:0] pos;
        t_word [2:0] vel;
        logic        moved;
    } t_motion;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [WORD_W-1:0]    cfg_data;

    pms_item_if   item_bus ();
    pms_result_if result_bus ();

    projectile_motion_step i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_item     (item_bus),
        .o_result   (result_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    t_word          grav_air [3];
    t_word          grav_liq [3];
    logic [DT_W-1:0] dt_air;
    logic [DT_W-1:0] dt_liq;

    t_motion expected_motion [$];
    t_motion oldest_motion;
    int      mismatch_count = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      stall_left = 0;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint round_shift(input longint x, input int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic t_word clamp_word(input longint v);
        if (v > longint'(WORD_MAX)) begin
            return WORD_MAX;
        end else if (v < longint'(WORD_MIN)) begin
            return WORD_MIN;
        end
        return t_word'(v);
    endfunction

    function automatic longint unsigned mag_sq(input longint a, input longint b,
                                               input longint c);
        return longint'(a * a) + longint'(b * b) + longint'(c * c);
    endfunction

    function automatic t_motion predict_motion(input t_object o);
        t_motion r;
        longint  pos [3];
        longint  vel [3];
        longint  acc [3];
        longint  grav [3];
        longint  dt, half, k, gs, dv, dp;
        logic    liquid;
        r.pos = o.pos;
        r.vel = o.vel;
        r.moved = 1'b0;
        if (o.flags[FLAG_REST]) begin
            return r;
        end
        liquid = o.flags[FLAG_LIQUID];
        for (int i = 0; i < 3; i++) begin
            pos[i] = $signed(o.pos[i]);
            vel[i] = $signed(o.vel[i]);
            acc[i] = $signed(o.acc[i]);
            grav[i] = liquid ? $signed(grav_liq[i]) : $signed(grav_air[i]);
        end
        dt = liquid ? longint'(dt_liq) : longint'(dt_air);
        half = round_shift(dt * dt, 17);
        if (mag_sq(acc[0], acc[1], acc[2]) < longint'(SMALL_MAGSQ)) begin
            acc[0] = 0;
            acc[1] = 0;
            acc[2] = 0;
        end
        if (mag_sq(vel[0], vel[1], vel[2]) < longint'(SMALL_MAGSQ)) begin
            vel[0] = 0;
            vel[1] = 0;
            vel[2] = 0;
        end
        if (o.flags[FLAG_NO_GRAV]) begin
            k = 0;
        end else begin
            k = o.flags[FLAG_HALF] ? longint'(SCALE_FIFTH) : longint'(SCALE_HALF);
        end
        for (int i = 0; i < 3; i++) begin
            gs = (k != 0) ? round_shift(grav[i] * k, 16) : 0;
            dv = round_shift((gs + acc[i]) * dt, 16);
            dp = round_shift(acc[i] * half + vel[i] * dt, 16);
            r.pos[i] = clamp_word(pos[i] + dp);
            r.vel[i] = clamp_word(vel[i] + dv);
        end
        r.moved = 1'b1;
        return r;
    endfunction

    function automatic t_object make_object(input t_word px, py, pz, vx, vy, vz,
                                            input t_word ax, ay, az,
                                            input logic [FLAGS_W-1:0] flags);
        t_object o;
        o.pos = {pz, py, px};
        o.vel = {vz, vy, vx};
        o.acc = {az, ay, ax};
        o.flags = flags;
        return o;
    endfunction

    function automatic t_word rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return WORD_MAX;
            2: return WORD_MIN;
            3, 4: return t_word'(int'($urandom_range(0, 13200)) - 6600);
            5, 6: return t_word'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            default: return t_word'($urandom);
        endcase
    endfunction

    function automatic t_object rand_object();
        t_object o;
        logic    small_vel, small_acc;
        small_vel = ($urandom_range(0, 3) == 0);
        small_acc = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < 3; i++) begin
            o.pos[i] = rand_word();
            o.vel[i] = small_vel ? t_word'(int'($urandom_range(0, 7600)) - 3800)
                                 : rand_word();
            o.acc[i] = small_acc ? t_word'(int'($urandom_range(0, 7600)) - 3800)
                                 : rand_word();
        end
        o.flags = FLAGS_W'($urandom_range(0, 15));
        if ($urandom_range(0, 4) != 0) begin
            o.flags[FLAG_REST] = 1'b0;
        end
        return o;
    endfunction

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %h, actual %h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && result_bus.valid && result_bus.ready) begin
            if (expected_motion.size() == 0) begin
                $error("result item with no expectation pending");
                mismatch_count++;
            end else begin
                oldest_motion = expected_motion.pop_front();
                check_field("new_pos_x", oldest_motion.pos[0], result_bus.new_pos_x);
                check_field("new_pos_y", oldest_motion.pos[1], result_bus.new_pos_y);
                check_field("new_pos_z", oldest_motion.pos[2], result_bus.new_pos_z);
                check_field("new_vel_x", oldest_motion.vel[0], result_bus.new_vel_x);
                check_field("new_vel_y", oldest_motion.vel[1], result_bus.new_vel_y);
                check_field("new_vel_z", oldest_motion.vel[2], result_bus.new_vel_z);
                check_field("moved", WORD_W'(oldest_motion.moved),
                            WORD_W'(result_bus.moved));
            end
        end
    end

    initial begin
        result_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                result_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                result_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_item(input t_object o);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_bus.valid <= 1'b0;
            @(negedge clk);
        end
        item_bus.pos_x <= o.pos[0];
        item_bus.pos_y <= o.pos[1];
        item_bus.pos_z <= o.pos[2];
        item_bus.vel_x <= o.vel[0];
        item_bus.vel_y <= o.vel[1];
        item_bus.vel_z <= o.vel[2];
        item_bus.accel_x <= o.acc[0];
        item_bus.accel_y <= o.acc[1];
        item_bus.accel_z <= o.acc[2];
        item_bus.motion_flags <= o.flags;
        item_bus.valid <= 1'b1;
        do @(posedge clk); while (!item_bus.ready);
        expected_motion.push_back(predict_motion(o));
        @(negedge clk);
    endtask

    task automatic wait_idle();
        item_bus.valid <= 1'b0;
        while (expected_motion.size() != 0) @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [WORD_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        case (idx)
            CFG_NGRAV_X: grav_air[0] = data;
            CFG_NGRAV_Y: grav_air[1] = data;
            CFG_NGRAV_Z: grav_air[2] = data;
            CFG_LGRAV_X: grav_liq[0] = data;
            CFG_LGRAV_Y: grav_liq[1] = data;
            CFG_LGRAV_Z: grav_liq[2] = data;
            CFG_NDT:     dt_air = data[DT_W-1:0];
            CFG_LDT:     dt_liq = data[DT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_physics(input t_word gnx, gny, gnz, glx, gly, glz,
                               input logic [WORD_W-1:0] dtn, dtl);
        wait_idle();
        cfg_write(CFG_NGRAV_X, gnx);
        cfg_write(CFG_NGRAV_Y, gny);
        cfg_write(CFG_NGRAV_Z, gnz);
        cfg_write(CFG_LGRAV_X, glx);
        cfg_write(CFG_LGRAV_Y, gly);
        cfg_write(CFG_LGRAV_Z, glz);
        cfg_write(CFG_NDT, dtn);
        cfg_write(CFG_LDT, dtl);
        cfg_we <= 1'b0;
    endtask

    task automatic test_flag_modes();
        set_physics(13107, -642253, -6554, -3277, -131072, 65536, 1092, 2185);
        send_item(make_object(0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
        send_item(make_object(655360, -65536, 0, 131072, 0, -65536, 0, 65536, 0,
                              M_NO_GRAV));
        send_item(make_object(-655360, 65536, 12345, 0, 262144, 0, 65536, 0, 0,
                              M_HALF));
        send_item(make_object(1, 2, 3, 65536, 65536, 65536, 0, 0, 0,
                              M_HALF | M_NO_GRAV));
        send_item(make_object(0, 0, 0, -131072, 0, 0, 0, 0, 32768, M_LIQUID));
        send_item(make_object(0, 0, 0, 0, 0, 0, 0, 0, 0, M_LIQUID | M_HALF));
        send_item(make_object(WORD_MAX, WORD_MIN, 0, WORD_MIN, WORD_MAX, -1,
                              WORD_MAX, WORD_MIN, 7, M_REST));
        send_item(make_object(99999, -5, 42, 3, 3, 3, 65536, 0, 0,
                              M_REST | M_LIQUID | M_HALF | M_NO_GRAV));
        wait_idle();
    endtask

    task automatic test_small_vectors();
        // Single axis just below and just above the small-magnitude threshold.
        send_item(make_object(0, 0, 0, 0, -6553, 0, 6553, 0, 0, '0));
        send_item(make_object(0, 0, 0, 0, 6554, 0, 6554, 0, 0, '0));
        // All three axes just below and just above the threshold, split across components.
        send_item(make_object(65536, 0, 0, 3783, -3783, 3783, 3783, 3783, -3783, '0));
        send_item(make_object(65536, 0, 0, 3784, -3784, 3784, -3784, 3784, 3784,
                              M_LIQUID));
        wait_idle();
    endtask

    task automatic test_saturation();
        set_physics(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MIN,
                    32'hFFFF_FFFF, 65536);
        send_item(make_object(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                              WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, '0));
        send_item(make_object(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                              WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, M_LIQUID));
        send_item(make_object(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX,
                              WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, M_HALF));
        send_item(make_object(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN,
                              WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN,
                              M_LIQUID | M_HALF));
        send_item(make_object(0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
        send_item(make_object(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX,
                              WORD_MIN, 0, 0, 0, M_REST));
        wait_idle();
    endtask

    task automatic test_zero_step();
        set_physics(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                    rand_word(), '0, '0);
        send_item(make_object(655360, -655360, 1, 196608, -65536, 0, 65536, 0,
                              -65536, '0));
        send_item(make_object(-1, 0, 1, 0, 131072, 0, 0, 0, 65536, M_LIQUID));
        wait_idle();
    endtask

    task automatic test_random_motion(input int count);
        repeat (count) send_item(rand_object());
        wait_idle();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge clk);
        stall_left = 80;
        @(negedge clk);
        repeat (40) send_item(rand_object());
        wait_idle();
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        item_bus.valid = 1'b0;
        item_bus.pos_x = '0;
        item_bus.pos_y = '0;
        item_bus.pos_z = '0;
        item_bus.vel_x = '0;
        item_bus.vel_y = '0;
        item_bus.vel_z = '0;
        item_bus.accel_x = '0;
        item_bus.accel_y = '0;
        item_bus.accel_z = '0;
        item_bus.motion_flags = '0;
        for (int i = 0; i < 3; i++) begin
            grav_air[i] = '0;
            grav_liq[i] = '0;
        end
        dt_air = '0;
        dt_liq = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_flag_modes();
        test_small_vectors();
        test_saturation();
        test_zero_step();

        send_idle_pct = 18;
        recv_idle_pct = 55;
        set_physics(13107, -642253, 0, 0, -131072, -6554, 1092, 2185);
        test_random_motion(250);
        set_physics(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                    rand_word(), $urandom_range(0, 4000), $urandom_range(0, 4000));
        test_random_motion(250);

        send_idle_pct = 55;
        recv_idle_pct = 18;
        set_physics(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN,
                    32'hFFFF_FFFF, 65536);
        test_random_motion(250);
        set_physics(t_word'($urandom), t_word'($urandom), t_word'($urandom),
                    t_word'($urandom), t_word'($urandom), t_word'($urandom),
                    $urandom, $urandom);
        test_random_motion(250);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_physics(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                    rand_word(), '0, '0);
        test_random_motion(250);
        set_physics(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                    rand_word(), 1, 65536);
        test_random_motion(250);

        test_backpressure();

        wait_idle();
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
